>>> hdl/bwd_pkg.sv
// Shared types, codes and tables of the button and wheel event decoder.
`timescale 1ns / 1ps

package bwd_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;
  localparam int NSLOTS = 11;
  localparam int SLOT_W = 4;

  typedef enum logic [2:0] {
    ACT_KEY           = 3'd0,
    ACT_SCROLL_FRONT  = 3'd1,
    ACT_SCROLL_BACK   = 3'd2,
    ACT_CONTRAST_UP   = 3'd3,
    ACT_CONTRAST_DOWN = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    STEP_NONE  = 2'd0,
    STEP_LEFT  = 2'd1,
    STEP_RIGHT = 2'd2
  } step_t;

  typedef enum logic [SLOT_W-1:0] {
    SLOT_FF         = 4'd0,
    SLOT_ACTION     = 4'd1,
    SLOT_PAUSE      = 4'd2,
    SLOT_REWIND     = 4'd3,
    SLOT_MENU       = 4'd4,
    SLOT_CTRL_DOWN  = 4'd5,
    SLOT_LET_DOWN   = 4'd6,
    SLOT_LET_UP     = 4'd7,
    SLOT_CTRL_UP    = 4'd8,
    SLOT_WHEEL_DOWN = 4'd9,
    SLOT_WHEEL_UP   = 4'd10
  } slot_t;

  localparam logic [6:0] KEY_WHEEL_R = 7'h13;
  localparam logic [6:0] KEY_WHEEL_L = 7'h26;
  localparam logic [6:0] KEY_ACTION  = 7'd28;
  localparam logic [6:0] KEY_CTRL    = 7'd29;
  localparam logic [6:0] KEY_Q       = 7'd16;
  localparam logic [6:0] KEY_S       = 7'd31;
  localparam logic [6:0] KEY_NONE    = 7'd0;

  localparam int BIT_FF     = 0;
  localparam int BIT_ACTION = 1;
  localparam int BIT_PAUSE  = 2;
  localparam int BIT_REWIND = 3;
  localparam int BIT_MENU   = 4;
  localparam int BIT_HOLD   = 5;
  localparam int BIT_WHEEL0 = 6;
  localparam int BIT_WHEEL1 = 7;

  typedef struct packed {
    logic [NSLOTS-1:0] slots;
    logic              action_down;
    logic [6:0]        letter;
    logic [6:0]        wheel_code;
  } cmd_t;

  typedef struct packed {
    act_t       action;
    logic [6:0] key_code;
    logic       key_down;
  } result_t;

  function automatic step_t wheel_step(input logic [1:0] old_ph, input logic [1:0] new_ph);
    step_t s;
    case ({old_ph, new_ph})
      4'b0001: s = STEP_LEFT;
      4'b0010: s = STEP_RIGHT;
      4'b0100: s = STEP_RIGHT;
      4'b0111: s = STEP_LEFT;
      4'b1000: s = STEP_LEFT;
      4'b1011: s = STEP_RIGHT;
      4'b1101: s = STEP_RIGHT;
      4'b1110: s = STEP_LEFT;
      default: s = STEP_NONE;
    endcase
    return s;
  endfunction

endpackage

>>> hdl/button_and_wheel_event_decoder.sv
// Top level of the button and wheel event decoder.
`timescale 1ns / 1ps

// Turns keypad pin-change events into a run of zero to eleven action and key
// results, one per transfer, with tlast on the final result of each event.
// One event is taken every clock while the four-entry command queue has room;
// events that yield nothing leave no trace on the output. Results leave at one
// per clock while m_tready stays high, so an event's results (up to eleven)
// hold the output side until its run ends; the result sequencer reloads from the queue in the same
// cycle that it sends a run's final result.
module button_and_wheel_event_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // change_mask[7:0], pin_levels[15:8]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // action[2:0], key_code[9:3], key_down[10], zero[15:11]
  output logic        m_tlast
);

  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_valid;
  bwd_pkg::cmd_t q_in;
  bwd_pkg::cmd_t q_head;

  bwd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .change_mask (s_tdata[7:0]),
    .pin_levels  (s_tdata[15:8]),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_in)
  );

  bwd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  bwd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

>>> hdl/bwd_front.sv
// Front end: accepts pin-change events, tracks wheel phase and queues result commands.
`timescale 1ns / 1ps

module bwd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    change_mask,
  input  logic [7:0]    pin_levels,
  input  logic          q_full,
  output logic          q_push,
  output bwd_pkg::cmd_t q_cmd
);

  logic                 wheel_known;
  logic [1:0]           wheel_phase;
  logic                 take;
  logic                 wheel_hit;
  logic [1:0]           now_phase;
  bwd_pkg::step_t       step;
  logic                 step_hit;

  assign in_ready  = !q_full;
  assign take      = in_valid && in_ready;
  assign wheel_hit = change_mask[bwd_pkg::BIT_WHEEL0] || change_mask[bwd_pkg::BIT_WHEEL1];
  assign now_phase = pin_levels[bwd_pkg::BIT_WHEEL1:bwd_pkg::BIT_WHEEL0];
  assign step      = bwd_pkg::wheel_step(wheel_phase, now_phase);
  assign step_hit  = wheel_hit && wheel_known && (step != bwd_pkg::STEP_NONE);

  always_comb begin
    q_cmd.slots = '0;
    q_cmd.slots[bwd_pkg::SLOT_FF] =
      change_mask[bwd_pkg::BIT_FF] && pin_levels[bwd_pkg::BIT_FF];
    q_cmd.slots[bwd_pkg::SLOT_ACTION] = change_mask[bwd_pkg::BIT_ACTION];
    q_cmd.slots[bwd_pkg::SLOT_PAUSE] =
      change_mask[bwd_pkg::BIT_PAUSE] && pin_levels[bwd_pkg::BIT_PAUSE];
    q_cmd.slots[bwd_pkg::SLOT_REWIND] =
      change_mask[bwd_pkg::BIT_REWIND] && pin_levels[bwd_pkg::BIT_REWIND];
    q_cmd.slots[bwd_pkg::SLOT_MENU] =
      change_mask[bwd_pkg::BIT_MENU] && pin_levels[bwd_pkg::BIT_MENU];
    q_cmd.slots[bwd_pkg::SLOT_CTRL_DOWN] = change_mask[bwd_pkg::BIT_HOLD];
    q_cmd.slots[bwd_pkg::SLOT_LET_DOWN]  = change_mask[bwd_pkg::BIT_HOLD];
    q_cmd.slots[bwd_pkg::SLOT_LET_UP]    = change_mask[bwd_pkg::BIT_HOLD];
    q_cmd.slots[bwd_pkg::SLOT_CTRL_UP]   = change_mask[bwd_pkg::BIT_HOLD];
    q_cmd.slots[bwd_pkg::SLOT_WHEEL_DOWN] = step_hit;
    q_cmd.slots[bwd_pkg::SLOT_WHEEL_UP]   = step_hit;
    q_cmd.action_down = !pin_levels[bwd_pkg::BIT_ACTION];
    q_cmd.letter      = pin_levels[bwd_pkg::BIT_HOLD] ? bwd_pkg::KEY_S : bwd_pkg::KEY_Q;
    q_cmd.wheel_code  = (step == bwd_pkg::STEP_LEFT) ? bwd_pkg::KEY_WHEEL_L
                                                     : bwd_pkg::KEY_WHEEL_R;
  end

  // drop events that yield no result
  assign q_push = take && (q_cmd.slots != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_known <= 1'b0;
      wheel_phase <= 2'd0;
    end else if (take && wheel_hit) begin
      wheel_known <= 1'b1;
      wheel_phase <= now_phase;
    end
  end

endmodule

>>> hdl/bwd_fifo.sv
// Short command queue between the front and back ends.
`timescale 1ns / 1ps

module bwd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bwd_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output bwd_pkg::cmd_t head
);

  bwd_pkg::cmd_t                mem [bwd_pkg::QDEPTH];
  logic [bwd_pkg::QPTR_W-1:0]   wr_ptr;
  logic [bwd_pkg::QPTR_W-1:0]   rd_ptr;
  logic [bwd_pkg::QCNT_W-1:0]   count;

  assign full      = (count == bwd_pkg::QCNT_W'(bwd_pkg::QDEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/bwd_back.sv
// Back end: walks the pending result slots of a command and drives the result stream.
`timescale 1ns / 1ps

module bwd_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  bwd_pkg::cmd_t q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [15:0]   out_data,
  output logic          out_last
);

  logic [bwd_pkg::NSLOTS-1:0] pend;
  logic [bwd_pkg::NSLOTS-1:0] pend_next;
  logic [bwd_pkg::NSLOTS-1:0] low;
  bwd_pkg::cmd_t              cmd;
  logic                       emit;
  logic                       fin;
  logic [bwd_pkg::SLOT_W-1:0] idx;
  bwd_pkg::result_t           res;

  assign low  = pend & (~pend + 1'b1);
  assign fin  = ((pend & ~low) == '0);
  assign emit = (pend != '0) && (!out_valid || out_ready);
  assign q_pop = q_valid && ((pend == '0) || (emit && fin));

  always_comb begin
    idx = '0;
    for (int i = 0; i < bwd_pkg::NSLOTS; i++) begin
      if (low[i]) begin
        idx = bwd_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    res.action   = bwd_pkg::ACT_KEY;
    res.key_code = bwd_pkg::KEY_NONE;
    res.key_down = 1'b0;
    case (bwd_pkg::slot_t'(idx))
      bwd_pkg::SLOT_FF:     res.action = bwd_pkg::ACT_SCROLL_FRONT;
      bwd_pkg::SLOT_ACTION: begin
        res.key_code = bwd_pkg::KEY_ACTION;
        res.key_down = cmd.action_down;
      end
      bwd_pkg::SLOT_PAUSE:  res.action = bwd_pkg::ACT_CONTRAST_DOWN;
      bwd_pkg::SLOT_REWIND: res.action = bwd_pkg::ACT_SCROLL_BACK;
      bwd_pkg::SLOT_MENU:   res.action = bwd_pkg::ACT_CONTRAST_UP;
      bwd_pkg::SLOT_CTRL_DOWN: begin
        res.key_code = bwd_pkg::KEY_CTRL;
        res.key_down = 1'b1;
      end
      bwd_pkg::SLOT_LET_DOWN: begin
        res.key_code = cmd.letter;
        res.key_down = 1'b1;
      end
      bwd_pkg::SLOT_LET_UP:  res.key_code = cmd.letter;
      bwd_pkg::SLOT_CTRL_UP: res.key_code = bwd_pkg::KEY_CTRL;
      bwd_pkg::SLOT_WHEEL_DOWN: begin
        res.key_code = cmd.wheel_code;
        res.key_down = 1'b1;
      end
      bwd_pkg::SLOT_WHEEL_UP: res.key_code = cmd.wheel_code;
      default: res.key_code = bwd_pkg::KEY_NONE;
    endcase
  end

  always_comb begin
    pend_next = pend;
    if (q_pop) begin
      pend_next = q_head.slots;
    end else if (emit) begin
      pend_next = pend & ~low;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= {5'd0, res.key_down, res.key_code, res.action};
      out_last <= fin;
    end
  end

  a_pop_has_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("pop from empty queue");

  a_no_reload_midrun: assert property (@(posedge clk) disable iff (rst)
    (pend != '0 && !(emit && fin)) |=> (pend == ($past(pend) & ~$past(low))) ||
                                        (pend == $past(pend)))
    else $error("command reloaded before its run finished");

  a_emit_onehot: assert property (@(posedge clk) disable iff (rst)
    emit |-> $onehot(low)) else $error("slot select not one-hot");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> !$past(emit))
    else $error("result overwritten while stalled");

endmodule
